[src/smeu_pkg.sv]
// ============================================================================
// smeu_pkg
// Shared types, constants and command/status bundles for the stack machine
// execute unit.
// ============================================================================
`default_nettype none

package smeu_pkg;

    localparam int STACK_DEPTH = 2048;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CODE_DEPTH  = 512;
    localparam int PC_W        = $clog2(CODE_DEPTH);
    localparam int MAX_LEVELS  = 3;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = WORD_W + 2;
    localparam int ACTION_W    = 4;
    localparam int LEVEL_W     = 2;
    localparam int SUB_W       = 4;
    localparam int FAULT_W     = 2;

    localparam logic [ACTION_W-1:0] OP_LIT = 4'd1;
    localparam logic [ACTION_W-1:0] OP_OPR = 4'd2;
    localparam logic [ACTION_W-1:0] OP_LOD = 4'd3;
    localparam logic [ACTION_W-1:0] OP_STO = 4'd4;
    localparam logic [ACTION_W-1:0] OP_CAL = 4'd5;
    localparam logic [ACTION_W-1:0] OP_INC = 4'd6;
    localparam logic [ACTION_W-1:0] OP_JMP = 4'd7;
    localparam logic [ACTION_W-1:0] OP_JPC = 4'd8;
    localparam logic [ACTION_W-1:0] OP_SIO = 4'd9;

    localparam logic [SUB_W-1:0] OPR_RET = 4'd0;
    localparam logic [SUB_W-1:0] OPR_NEG = 4'd1;
    localparam logic [SUB_W-1:0] OPR_ADD = 4'd2;
    localparam logic [SUB_W-1:0] OPR_SUB = 4'd3;
    localparam logic [SUB_W-1:0] OPR_MUL = 4'd4;
    localparam logic [SUB_W-1:0] OPR_DIV = 4'd5;
    localparam logic [SUB_W-1:0] OPR_ODD = 4'd6;
    localparam logic [SUB_W-1:0] OPR_MOD = 4'd7;
    localparam logic [SUB_W-1:0] OPR_EQL = 4'd8;
    localparam logic [SUB_W-1:0] OPR_NEQ = 4'd9;
    localparam logic [SUB_W-1:0] OPR_LSS = 4'd10;
    localparam logic [SUB_W-1:0] OPR_LEQ = 4'd11;
    localparam logic [SUB_W-1:0] OPR_GTR = 4'd12;
    localparam logic [SUB_W-1:0] OPR_GEQ = 4'd13;

    localparam logic [SUB_W-1:0] SIO_OUT  = 4'd0;
    localparam logic [SUB_W-1:0] SIO_IN   = 4'd1;
    localparam logic [SUB_W-1:0] SIO_HALT = 4'd2;

    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_DIV  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_ADDR = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [LEVEL_W-1:0]       level;
        logic signed [WORD_W-1:0] operand;
        logic signed [WORD_W-1:0] read_value;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic [STACK_AW-1:0]      frame_base;
        logic [STACK_AW-1:0]      stack_top_index;
        logic signed [WORD_W-1:0] top_value;
        logic                     out_valid;
        logic signed [WORD_W-1:0] out_value;
        logic                     is_halted;
        logic [FAULT_W-1:0]       fault;
    } result_t;

    typedef enum logic [3:0] {
        A_TOP, A_TOP_M1, A_TOP_P1, A_TOP_P2, A_TOP_P3, A_TOP_P4,
        A_FP_P2, A_FP_P3, A_BASE_P1, A_BASE_M, A_CLEAR
    } addr_sel_t;

    typedef enum logic [2:0] {
        W_ZERO, W_OPERAND, W_READ_VALUE, W_BASE, W_FP, W_PC, W_RES, W_RDATA
    } wdata_sel_t;

    typedef enum logic [1:0] {PC_HOLD, PC_INC, PC_TARGET, PC_RA} pc_sel_t;
    typedef enum logic [2:0] {T_HOLD, T_P1, T_M1, T_ADD_M, T_FP_M1} top_sel_t;
    typedef enum logic [1:0] {F_HOLD, F_TOP_P1, F_DL} fp_sel_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE,
        S_WALK_RD, S_WALK_LD,
        S_LOD_RD, S_LOD_WR, S_STO_RD, S_STO_WR,
        S_CAL_W0, S_CAL_W1, S_CAL_W2, S_CAL_W3,
        S_RET_RD2, S_RET_LD,
        S_UN_LD, S_BIN_RDC, S_BIN_LD, S_ALU, S_DIV_WAIT, S_OPR_WR,
        S_JPC_LD, S_SIO_LD,
        S_TOP_RD, S_TOP_LD
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic       wr_en;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       ld_a;
        logic       ld_c;
        logic       ld_base;
        logic       ld_out;
        logic       ld_res;
        logic       div_start;
        logic       fault_div;
        logic       commit;
        pc_sel_t    pc_sel;
        top_sel_t   top_sel;
        fp_sel_t    fp_sel;
        logic       set_halt;
        logic       clr_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SUB_W-1:0]    sub;
        logic                sub_ok;
        logic                lvl_zero;
        logic                lvl_last;
        logic                opc_zero;
        logic                rd_zero;
        logic                div_done;
        logic                halted;
        logic                out_room;
        logic                clr_last;
    } status_t;

endpackage

`default_nettype wire

[src/smeu_ram.sv]
// ============================================================================
// smeu_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/smeu_div.sv]
// ============================================================================
// smeu_div
// Signed 32-bit divider, one quotient bit per cycle, truncating quotient and
// remainder with the sign of the dividend.
// ============================================================================
`default_nettype none

module smeu_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [smeu_pkg::WORD_W-1:0] dividend,
    input  wire logic signed [smeu_pkg::WORD_W-1:0] divisor,
    output logic                                    done,
    output logic signed [smeu_pkg::WORD_W-1:0]      quotient,
    output logic signed [smeu_pkg::WORD_W-1:0]      remainder
);
    import smeu_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] rem_reg;
    logic              qneg_reg;
    logic              rneg_reg;
    logic [WORD_W:0]   shift;
    logic [WORD_W:0]   diff;

    assign shift = {rem_reg, quo_reg[WORD_W-1]};
    assign diff  = shift - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg  <= divisor[WORD_W-1] ? WORD_W'(-divisor) : WORD_W'(divisor);
            quo_reg  <= dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
            rem_reg  <= '0;
            qneg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            rneg_reg <= dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[WORD_W] ? shift[WORD_W-1:0] : diff[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], ~diff[WORD_W]};
        end
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? $signed(-quo_reg) : $signed(quo_reg);
    assign remainder = rneg_reg ? $signed(-rem_reg) : $signed(rem_reg);

endmodule

`default_nettype wire

[src/smeu_dp.sv]
// ============================================================================
// smeu_dp
// Datapath: machine registers, stack memory, address and write muxes, ALU,
// divider and the result word register.
// ============================================================================
`default_nettype none

module smeu_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smeu_pkg::instr_t  instr,
    input  wire smeu_pkg::cmd_t    cmd,
    output smeu_pkg::status_t      status,
    output smeu_pkg::result_t      result,
    output logic                   result_valid,
    input  wire logic              result_stall
);
    import smeu_pkg::*;

    instr_t                   ir_reg;
    logic [PC_W-1:0]          pc_reg;
    logic [STACK_AW-1:0]      fp_reg;
    logic [STACK_AW-1:0]      top_reg;
    logic                     halt_reg;
    logic [FAULT_W-1:0]       fault_reg;
    logic [LEVEL_W-1:0]       cnt_reg;
    logic [STACK_AW-1:0]      clr_reg;
    logic                     rd_ok_reg;
    logic                     oflag_reg;
    logic signed [WORD_W-1:0] oval_reg;
    logic signed [ADDR_W-1:0] base_reg;
    logic signed [WORD_W-1:0] opa_reg;
    logic signed [WORD_W-1:0] opc_reg;
    logic signed [WORD_W-1:0] res_reg;
    logic                     rvalid_reg;
    result_t                  result_reg;

    logic signed [ADDR_W-1:0] top_a;
    logic signed [ADDR_W-1:0] fp_a;
    logic signed [ADDR_W-1:0] opnd_a;
    logic signed [ADDR_W-1:0] addr;
    logic                     in_range;
    logic [WORD_W-1:0]        wdata;
    logic [WORD_W-1:0]        rdata;
    logic signed [WORD_W-1:0] rd_word;
    logic signed [WORD_W-1:0] alu;
    logic [PC_W-1:0]          pc_inc;
    logic [LEVEL_W-1:0]       lvl_clamp;
    logic                     div_done;
    logic signed [WORD_W-1:0] div_q;
    logic signed [WORD_W-1:0] div_r;

    assign top_a   = $signed(ADDR_W'(top_reg));
    assign fp_a    = $signed(ADDR_W'(fp_reg));
    assign opnd_a  = {{(ADDR_W-WORD_W){ir_reg.operand[WORD_W-1]}}, ir_reg.operand};
    assign rd_word = rd_ok_reg ? $signed(rdata) : '0;
    assign pc_inc  = pc_reg + 1'b1;
    assign lvl_clamp = (int'(instr.level) > MAX_LEVELS) ? LEVEL_W'(MAX_LEVELS) : instr.level;

    always_comb
    begin
        case (cmd.addr_sel)
            A_TOP:     addr = top_a;
            A_TOP_M1:  addr = top_a - ADDR_W'(1);
            A_TOP_P1:  addr = top_a + ADDR_W'(1);
            A_TOP_P2:  addr = top_a + ADDR_W'(2);
            A_TOP_P3:  addr = top_a + ADDR_W'(3);
            A_TOP_P4:  addr = top_a + ADDR_W'(4);
            A_FP_P2:   addr = fp_a + ADDR_W'(2);
            A_FP_P3:   addr = fp_a + ADDR_W'(3);
            A_BASE_P1: addr = base_reg + ADDR_W'(1);
            A_BASE_M:  addr = base_reg + opnd_a;
            A_CLEAR:   addr = $signed(ADDR_W'(clr_reg));
            default:   addr = top_a;
        endcase
    end

    assign in_range = !addr[ADDR_W-1] && (addr < $signed(ADDR_W'(STACK_DEPTH)));

    always_comb
    begin
        case (cmd.wdata_sel)
            W_ZERO:       wdata = '0;
            W_OPERAND:    wdata = ir_reg.operand;
            W_READ_VALUE: wdata = ir_reg.read_value;
            W_BASE:       wdata = base_reg[WORD_W-1:0];
            W_FP:         wdata = WORD_W'(fp_reg);
            W_PC:         wdata = WORD_W'(pc_inc);
            W_RES:        wdata = res_reg;
            W_RDATA:      wdata = rd_word;
            default:      wdata = '0;
        endcase
    end

    always_comb
    begin
        case (ir_reg.operand[SUB_W-1:0])
            OPR_NEG: alu = -opa_reg;
            OPR_ODD: alu = opa_reg[0] ? (opa_reg[WORD_W-1] ? -WORD_W'(1) : WORD_W'(1)) : '0;
            OPR_ADD: alu = opa_reg + opc_reg;
            OPR_SUB: alu = opa_reg - opc_reg;
            OPR_MUL: alu = WORD_W'(opa_reg * opc_reg);
            OPR_DIV: alu = div_q;
            OPR_MOD: alu = div_r;
            OPR_EQL: alu = WORD_W'(opa_reg == opc_reg);
            OPR_NEQ: alu = WORD_W'(opa_reg != opc_reg);
            OPR_LSS: alu = WORD_W'(opa_reg < opc_reg);
            OPR_LEQ: alu = WORD_W'(opa_reg <= opc_reg);
            OPR_GTR: alu = WORD_W'(opa_reg > opc_reg);
            OPR_GEQ: alu = WORD_W'(opa_reg >= opc_reg);
            default: alu = '0;
        endcase
    end

    smeu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.wr_en && in_range),
        .waddr (addr[STACK_AW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (addr[STACK_AW-1:0]),
        .rdata (rdata)
    );

    smeu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (opa_reg),
        .divisor   (opc_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            fp_reg     <= STACK_AW'(1);
            top_reg    <= '0;
            halt_reg   <= 1'b0;
            fault_reg  <= FAULT_NONE;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            rd_ok_reg  <= 1'b0;
            oflag_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_ok_reg <= in_range;
            end
            if (cmd.accept)
            begin
                fault_reg <= FAULT_NONE;
                oflag_reg <= 1'b0;
                cnt_reg   <= lvl_clamp;
            end
            else
            begin
                if ((cmd.rd_en || cmd.wr_en) && !in_range && fault_reg == FAULT_NONE)
                begin
                    fault_reg <= FAULT_ADDR;
                end
                else if (cmd.fault_div && fault_reg == FAULT_NONE)
                begin
                    fault_reg <= FAULT_DIV;
                end
                if (cmd.ld_out)
                begin
                    oflag_reg <= 1'b1;
                end
                if (cmd.ld_base)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            if (cmd.commit)
            begin
                case (cmd.pc_sel)
                    PC_HOLD:   pc_reg <= pc_reg;
                    PC_INC:    pc_reg <= pc_inc;
                    PC_TARGET: pc_reg <= ir_reg.operand[PC_W-1:0];
                    PC_RA:     pc_reg <= opa_reg[PC_W-1:0];
                    default:   pc_reg <= pc_reg;
                endcase
                case (cmd.top_sel)
                    T_HOLD:  top_reg <= top_reg;
                    T_P1:    top_reg <= top_reg + 1'b1;
                    T_M1:    top_reg <= top_reg - 1'b1;
                    T_ADD_M: top_reg <= top_reg + ir_reg.operand[STACK_AW-1:0];
                    T_FP_M1: top_reg <= fp_reg - 1'b1;
                    default: top_reg <= top_reg;
                endcase
                case (cmd.fp_sel)
                    F_HOLD:   fp_reg <= fp_reg;
                    F_TOP_P1: fp_reg <= top_reg + 1'b1;
                    F_DL:     fp_reg <= rd_word[STACK_AW-1:0];
                    default:  fp_reg <= fp_reg;
                endcase
                if (cmd.set_halt)
                begin
                    halt_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                rvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ir_reg   <= instr;
            base_reg <= fp_a;
            oval_reg <= '0;
        end
        if (cmd.ld_base)
        begin
            base_reg <= {{(ADDR_W-WORD_W){rd_word[WORD_W-1]}}, rd_word};
        end
        if (cmd.ld_out)
        begin
            oval_reg <= rd_word;
        end
        if (cmd.ld_a)
        begin
            opa_reg <= rd_word;
        end
        if (cmd.ld_c)
        begin
            opc_reg <= rd_word;
        end
        if (cmd.ld_res)
        begin
            res_reg <= alu;
        end
        if (cmd.out_load)
        begin
            result_reg.next_pc         <= pc_reg;
            result_reg.frame_base      <= fp_reg;
            result_reg.stack_top_index <= top_reg;
            result_reg.top_value       <= rd_word;
            result_reg.out_valid       <= oflag_reg;
            result_reg.out_value       <= oval_reg;
            result_reg.is_halted       <= halt_reg;
            result_reg.fault           <= fault_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = rvalid_reg;

    assign status.action   = ir_reg.action;
    assign status.sub      = ir_reg.operand[SUB_W-1:0];
    assign status.sub_ok   = (ir_reg.operand[WORD_W-1:SUB_W] == '0);
    assign status.lvl_zero = (cnt_reg == '0);
    assign status.lvl_last = (cnt_reg == LEVEL_W'(1));
    assign status.opc_zero = (opc_reg == '0);
    assign status.rd_zero  = (rd_word == '0);
    assign status.div_done = div_done;
    assign status.halted   = halt_reg;
    assign status.out_room = !rvalid_reg || !result_stall;
    assign status.clr_last = (clr_reg == STACK_AW'(STACK_DEPTH - 1));

endmodule

`default_nettype wire

[src/smeu_ctrl.sv]
// ============================================================================
// smeu_ctrl
// Controller: sequences memory reads, writes, the static-link walk, the ALU
// and divider, and the pointer commit for each instruction word.
// ============================================================================
`default_nettype none

module smeu_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               instr_valid,
    input  wire smeu_pkg::status_t  status,
    output smeu_pkg::cmd_t          cmd,
    output logic                    idle
);
    import smeu_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t post_walk;
    logic   binary;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        post_walk  = S_LOD_RD;
        binary     = !(status.sub == OPR_NEG || status.sub == OPR_ODD);
        cmd        = '0;
        state_next = state_reg;
        case (status.action)
            OP_STO:  post_walk = S_STO_RD;
            OP_CAL:  post_walk = S_CAL_W0;
            default: post_walk = S_LOD_RD;
        endcase

        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_CLEAR;
                cmd.wdata_sel = W_ZERO;
                cmd.clr_step  = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (instr_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.pc_sel = PC_INC;
                state_next = S_TOP_RD;
                if (status.halted)
                begin
                    cmd.commit = 1'b1;
                    cmd.pc_sel = PC_HOLD;
                end
                else
                begin
                    case (status.action)
                        OP_LIT:
                        begin
                            cmd.wr_en     = 1'b1;
                            cmd.addr_sel  = A_TOP_P1;
                            cmd.wdata_sel = W_OPERAND;
                            cmd.commit    = 1'b1;
                            cmd.top_sel   = T_P1;
                        end
                        OP_OPR:
                        begin
                            if (!status.sub_ok)
                            begin
                                cmd.commit = 1'b1;
                            end
                            else
                            begin
                                case (status.sub)
                                    OPR_RET:
                                    begin
                                        cmd.rd_en    = 1'b1;
                                        cmd.addr_sel = A_FP_P3;
                                        state_next   = S_RET_RD2;
                                    end
                                    OPR_NEG, OPR_ODD:
                                    begin
                                        cmd.rd_en    = 1'b1;
                                        cmd.addr_sel = A_TOP;
                                        state_next   = S_UN_LD;
                                    end
                                    OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_MOD,
                                    OPR_EQL, OPR_NEQ, OPR_LSS, OPR_LEQ, OPR_GTR,
                                    OPR_GEQ:
                                    begin
                                        cmd.rd_en    = 1'b1;
                                        cmd.addr_sel = A_TOP_M1;
                                        state_next   = S_BIN_RDC;
                                    end
                                    default:
                                    begin
                                        cmd.commit = 1'b1;
                                    end
                                endcase
                            end
                        end
                        OP_LOD, OP_STO, OP_CAL:
                        begin
                            state_next = status.lvl_zero ? post_walk : S_WALK_RD;
                        end
                        OP_INC:
                        begin
                            cmd.commit  = 1'b1;
                            cmd.top_sel = T_ADD_M;
                        end
                        OP_JMP:
                        begin
                            cmd.commit = 1'b1;
                            cmd.pc_sel = PC_TARGET;
                        end
                        OP_JPC:
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.addr_sel = A_TOP;
                            state_next   = S_JPC_LD;
                        end
                        OP_SIO:
                        begin
                            if (status.sub_ok && status.sub == SIO_OUT)
                            begin
                                cmd.rd_en    = 1'b1;
                                cmd.addr_sel = A_TOP;
                                state_next   = S_SIO_LD;
                            end
                            else if (status.sub_ok && status.sub == SIO_IN)
                            begin
                                cmd.wr_en     = 1'b1;
                                cmd.addr_sel  = A_TOP_P1;
                                cmd.wdata_sel = W_READ_VALUE;
                                cmd.commit    = 1'b1;
                                cmd.top_sel   = T_P1;
                            end
                            else
                            begin
                                cmd.commit   = 1'b1;
                                cmd.set_halt = status.sub_ok && status.sub == SIO_HALT;
                            end
                        end
                        default:
                        begin
                            cmd.commit = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_BASE_P1;
                state_next   = S_WALK_LD;
            end
            S_WALK_LD:
            begin
                cmd.ld_base = 1'b1;
                state_next  = status.lvl_last ? post_walk : S_WALK_RD;
            end
            S_LOD_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_BASE_M;
                state_next   = S_LOD_WR;
            end
            S_LOD_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_TOP_P1;
                cmd.wdata_sel = W_RDATA;
                cmd.commit    = 1'b1;
                cmd.pc_sel    = PC_INC;
                cmd.top_sel   = T_P1;
                state_next    = S_TOP_RD;
            end
            S_STO_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_TOP;
                state_next   = S_STO_WR;
            end
            S_STO_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_BASE_M;
                cmd.wdata_sel = W_RDATA;
                cmd.commit    = 1'b1;
                cmd.pc_sel    = PC_INC;
                cmd.top_sel   = T_M1;
                state_next    = S_TOP_RD;
            end
            S_CAL_W0:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_TOP_P1;
                cmd.wdata_sel = W_ZERO;
                state_next    = S_CAL_W1;
            end
            S_CAL_W1:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_TOP_P2;
                cmd.wdata_sel = W_BASE;
                state_next    = S_CAL_W2;
            end
            S_CAL_W2:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_TOP_P3;
                cmd.wdata_sel = W_FP;
                state_next    = S_CAL_W3;
            end
            S_CAL_W3:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_TOP_P4;
                cmd.wdata_sel = W_PC;
                cmd.commit    = 1'b1;
                cmd.pc_sel    = PC_TARGET;
                cmd.fp_sel    = F_TOP_P1;
                state_next    = S_TOP_RD;
            end
            S_RET_RD2:
            begin
                cmd.ld_a     = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_FP_P2;
                state_next   = S_RET_LD;
            end
            S_RET_LD:
            begin
                cmd.commit  = 1'b1;
                cmd.pc_sel  = PC_RA;
                cmd.top_sel = T_FP_M1;
                cmd.fp_sel  = F_DL;
                state_next  = S_TOP_RD;
            end
            S_UN_LD:
            begin
                cmd.ld_a   = 1'b1;
                state_next = S_ALU;
            end
            S_BIN_RDC:
            begin
                cmd.ld_a     = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_TOP;
                state_next   = S_BIN_LD;
            end
            S_BIN_LD:
            begin
                cmd.ld_c   = 1'b1;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                if (status.sub == OPR_DIV || status.sub == OPR_MOD)
                begin
                    if (status.opc_zero)
                    begin
                        cmd.fault_div = 1'b1;
                        cmd.commit    = 1'b1;
                        cmd.pc_sel    = PC_INC;
                        cmd.top_sel   = T_M1;
                        state_next    = S_TOP_RD;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV_WAIT;
                    end
                end
                else
                begin
                    cmd.ld_res = 1'b1;
                    state_next = S_OPR_WR;
                end
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.ld_res = 1'b1;
                    state_next = S_OPR_WR;
                end
            end
            S_OPR_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wdata_sel = W_RES;
                cmd.addr_sel  = binary ? A_TOP_M1 : A_TOP;
                cmd.commit    = 1'b1;
                cmd.pc_sel    = PC_INC;
                cmd.top_sel   = binary ? T_M1 : T_HOLD;
                state_next    = S_TOP_RD;
            end
            S_JPC_LD:
            begin
                cmd.commit  = 1'b1;
                cmd.pc_sel  = status.rd_zero ? PC_TARGET : PC_INC;
                cmd.top_sel = T_M1;
                state_next  = S_TOP_RD;
            end
            S_SIO_LD:
            begin
                cmd.ld_out  = 1'b1;
                cmd.commit  = 1'b1;
                cmd.pc_sel  = PC_INC;
                cmd.top_sel = T_M1;
                state_next  = S_TOP_RD;
            end
            S_TOP_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_TOP;
                state_next   = S_TOP_LD;
            end
            S_TOP_LD:
            begin
                if (status.out_room)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

endmodule

`default_nettype wire

[src/stack_machine_execute_unit_top.sv]
// Throughput: one word at a time, set by the memory accesses of each opcode and by the
// divider for DIV and MOD; the next word can be taken in the cycle after the result is
// registered; a stalled result holds back the next result, not the next word.
// Reset: pc 0, base 1, top 0; then all 2048 stack words are cleared before the first word.
// ============================================================================
// stack_machine_execute_unit_top
// Execute unit of a small stack machine: controller and datapath.
// ============================================================================
`default_nettype none

module stack_machine_execute_unit_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smeu_pkg::instr_t  instr,
    input  wire logic              instr_valid,
    output logic                   instr_stall,
    output smeu_pkg::result_t      result,
    output logic                   result_valid,
    input  wire logic              result_stall
);
    import smeu_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    idle;

    smeu_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr_valid),
        .status      (status),
        .cmd         (cmd),
        .idle        (idle)
    );

    smeu_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr        (instr),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    assign instr_stall = !idle;

endmodule

`default_nettype wire

[src/smeu_checker.sv]
// ============================================================================
// smeu_checker
// Port-level checks on the result channel of the execute unit.
// ============================================================================
`default_nettype none

module smeu_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire smeu_pkg::result_t result,
    input wire logic              result_valid,
    input wire logic              result_stall
);
    import smeu_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result word changed while stalled");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.fault != 2'd3)
        else $error("undefined fault code");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.out_valid |-> result.out_value == '0)
        else $error("output value without output flag");

    a_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_valid |-> result.fault == FAULT_NONE
            && !result.is_halted)
        else $error("output word with fault or halt");

endmodule

bind stack_machine_execute_unit_top smeu_checker u_smeu_checker (.*);

`default_nettype wire

[bench/stack_machine_execute_unit_checker.sv]
// ============================================================================
// stack_machine_execute_unit_checker
// Watches the instruction and result channels of the stack machine execute
// unit, predicts each result from its own copy of the machine state and
// compares every field in order of arrival.
// ============================================================================
`default_nettype none

module stack_machine_execute_unit_checker
    import smeu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire instr_t  instr,
    input  wire logic    instr_valid,
    input  wire logic    instr_stall,
    input  wire result_t result,
    input  wire logic    result_valid,
    input  wire logic    result_stall,
    output int           fail_count,
    output int           pending
);

    logic signed [WORD_W-1:0] mem [STACK_DEPTH];
    logic [STACK_AW-1:0]      fp;
    logic [STACK_AW-1:0]      sp_reg;
    logic [PC_W-1:0]          pc_reg;
    logic                     halted;
    logic [FAULT_W-1:0]       step_fault;
    result_t                  expected_results [$];

    initial begin
        fail_count = 0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            mem[i] = '0;
        end
        fp = STACK_AW'(1);
        sp_reg = '0;
        pc_reg = '0;
        halted = 1'b0;
    end

    assign pending = expected_results.size();

    function automatic void note_fault(logic [FAULT_W-1:0] code);
        if (step_fault == FAULT_NONE)
        begin
            step_fault = code;
        end
    endfunction

    function automatic logic signed [WORD_W-1:0] load_word(longint addr);
        if (addr < 0 || addr >= STACK_DEPTH)
        begin
            note_fault(FAULT_ADDR);
            return '0;
        end
        return mem[addr];
    endfunction

    function automatic void store_word(longint addr, logic signed [WORD_W-1:0] value);
        if (addr < 0 || addr >= STACK_DEPTH)
        begin
            note_fault(FAULT_ADDR);
            return;
        end
        mem[addr] = value;
    endfunction

    function automatic longint follow_links(logic [LEVEL_W-1:0] lv);
        longint b;
        int n;
        b = fp;
        n = (lv > MAX_LEVELS) ? MAX_LEVELS : lv;
        for (int i = 0; i < n; i++)
        begin
            b = load_word(b + 1);
        end
        return b;
    endfunction

    function automatic logic [PC_W-1:0] wrap_pc(logic signed [WORD_W-1:0] t);
        return t[PC_W-1:0];
    endfunction

    function automatic void run_arith(logic signed [WORD_W-1:0] m, ref longint sp,
                                      ref logic [PC_W-1:0] pc);
        logic signed [WORD_W-1:0] a, c, r, ra, dl;
        if (m == OPR_RET)
        begin
            ra = load_word(longint'(fp) + 3);
            dl = load_word(longint'(fp) + 2);
            sp = longint'(fp) - 1;
            pc = wrap_pc(ra);
            fp = dl[STACK_AW-1:0];
            return;
        end
        if (m == OPR_NEG)
        begin
            a = load_word(sp);
            store_word(sp, -a);
            return;
        end
        if (m == OPR_ODD)
        begin
            a = load_word(sp);
            store_word(sp, a % 2);
            return;
        end
        if (m < OPR_ADD || m > OPR_GEQ)
        begin
            return;
        end
        sp -= 1;
        a = load_word(sp);
        c = load_word(sp + 1);
        case (m[SUB_W-1:0])
            OPR_ADD: r = a + c;
            OPR_SUB: r = a - c;
            OPR_MUL: r = a * c;
            OPR_DIV, OPR_MOD:
            begin
                if (c == 0)
                begin
                    note_fault(FAULT_DIV);
                    return;
                end
                if (c == -1)
                begin
                    r = (m == OPR_DIV) ? -a : '0;
                end
                else
                begin
                    r = (m == OPR_DIV) ? a / c : a % c;
                end
            end
            OPR_EQL: r = (a == c);
            OPR_NEQ: r = (a != c);
            OPR_LSS: r = (a < c);
            OPR_LEQ: r = (a <= c);
            OPR_GTR: r = (a > c);
            default: r = (a >= c);
        endcase
        store_word(sp, r);
    endfunction

    function automatic result_t execute_instr(instr_t ins);
        result_t res;
        longint sp;
        longint b;
        longint nfp;
        logic [PC_W-1:0] pc;
        logic signed [WORD_W-1:0] m;
        res = '0;
        step_fault = FAULT_NONE;
        m = ins.operand;
        sp = sp_reg;
        if (!halted)
        begin
            pc = pc_reg + 1'b1;
            case (ins.action)
                OP_LIT:
                begin
                    sp += 1;
                    store_word(sp, m);
                end
                OP_OPR: run_arith(m, sp, pc);
                OP_LOD:
                begin
                    b = follow_links(ins.level);
                    sp += 1;
                    store_word(sp, load_word(b + m));
                end
                OP_STO:
                begin
                    b = follow_links(ins.level);
                    store_word(b + m, load_word(sp));
                    sp -= 1;
                end
                OP_CAL:
                begin
                    b = follow_links(ins.level);
                    store_word(sp + 1, '0);
                    store_word(sp + 2, b[WORD_W-1:0]);
                    store_word(sp + 3, WORD_W'(fp));
                    store_word(sp + 4, WORD_W'(pc));
                    nfp = sp + 1;
                    fp = nfp[STACK_AW-1:0];
                    pc = wrap_pc(m);
                end
                OP_INC: sp += m;
                OP_JMP: pc = wrap_pc(m);
                OP_JPC:
                begin
                    if (load_word(sp) == 0)
                    begin
                        pc = wrap_pc(m);
                    end
                    sp -= 1;
                end
                OP_SIO:
                begin
                    if (m == SIO_OUT)
                    begin
                        res.out_value = load_word(sp);
                        res.out_valid = 1'b1;
                        sp -= 1;
                    end
                    else if (m == SIO_IN)
                    begin
                        sp += 1;
                        store_word(sp, ins.read_value);
                    end
                    else if (m == SIO_HALT)
                    begin
                        halted = 1'b1;
                    end
                end
                default: ;
            endcase
            pc_reg = pc;
            sp_reg = sp[STACK_AW-1:0];
        end
        res.next_pc = pc_reg;
        res.frame_base = fp;
        res.stack_top_index = sp_reg;
        res.top_value = mem[sp_reg];
        res.is_halted = halted;
        res.fault = step_fault;
        return res;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && instr_valid && !instr_stall)
        begin
            expected_results.push_back(execute_instr(instr));
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.next_pc !== want.next_pc)
                begin
                    $error("next_pc expected %0d got %0d", want.next_pc, result.next_pc);
                    fail_count++;
                end
                if (result.frame_base !== want.frame_base)
                begin
                    $error("frame_base expected %0d got %0d", want.frame_base,
                           result.frame_base);
                    fail_count++;
                end
                if (result.stack_top_index !== want.stack_top_index)
                begin
                    $error("stack_top_index expected %0d got %0d", want.stack_top_index,
                           result.stack_top_index);
                    fail_count++;
                end
                if (result.top_value !== want.top_value)
                begin
                    $error("top_value expected %0d got %0d", want.top_value,
                           result.top_value);
                    fail_count++;
                end
                if (result.out_valid !== want.out_valid)
                begin
                    $error("out_valid expected %0d got %0d", want.out_valid,
                           result.out_valid);
                    fail_count++;
                end
                if (result.out_value !== want.out_value)
                begin
                    $error("out_value expected %0d got %0d", want.out_value,
                           result.out_value);
                    fail_count++;
                end
                if (result.is_halted !== want.is_halted)
                begin
                    $error("is_halted expected %0d got %0d", want.is_halted,
                           result.is_halted);
                    fail_count++;
                end
                if (result.fault !== want.fault)
                begin
                    $error("fault expected %0d got %0d", want.fault, result.fault);
                    fail_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire

[bench/stack_machine_execute_unit_top_test.sv]
// ============================================================================
// stack_machine_execute_unit_top_test
// Drives instruction words into the stack machine execute unit: a directed
// opening over every opcode and corner case, then short random programs
// with random gaps and result stalls. The checker does the comparing.
// ============================================================================
`default_nettype none

module stack_machine_execute_unit_top_test;
    import smeu_pkg::*;

    logic    clk;
    logic    rst_n;
    instr_t  instr;
    logic    instr_valid;
    logic    instr_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;
    int      fail_count;
    int      pending;
    logic    stall_on;

    stack_machine_execute_unit_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr        (instr),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    stack_machine_execute_unit_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr        (instr),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #30000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // hold each stall level for a random count of cycles
    initial
    begin
        int n;
        result_stall = 1'b0;
        stall_on = 1'b1;
        forever
        begin
            n = $urandom_range(0, 14);
            @(posedge clk);
            result_stall <= stall_on ? ($urandom_range(0, 1) == 1) : 1'b0;
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_word(logic [ACTION_W-1:0] act, logic [LEVEL_W-1:0] lv,
                             logic signed [WORD_W-1:0] opd, logic signed [WORD_W-1:0] rv,
                             int gap);
        repeat (gap) @(posedge clk);
        instr <= '{action: act, level: lv, operand: opd, read_value: rv};
        instr_valid <= 1'b1;
        do
            @(posedge clk);
        while (instr_stall);
        instr_valid <= 1'b0;
    endtask

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return -1;
            3: return 0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_rand(logic [ACTION_W-1:0] act, logic signed [WORD_W-1:0] opd);
        int g;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        send_word(act, LEVEL_W'($urandom_range(0, 3)), opd, rand_word(), g);
    endtask

    initial
    begin
        int k;
        int choice;
        instr = '0;
        instr_valid = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_LIT, 0, 32'sh7fffffff, 0, 0);
        send_word(OP_LIT, 0, 32'sh80000000, 0, 0);
        send_word(OP_OPR, 0, OPR_ADD, 0, 0);
        send_word(OP_LIT, 0, 0, 0, 0);
        send_word(OP_OPR, 0, OPR_DIV, 0, 0);
        send_word(OP_LIT, 0, 32'sh80000000, 0, 0);
        send_word(OP_LIT, 0, -1, 0, 0);
        send_word(OP_OPR, 0, OPR_DIV, 0, 0);
        send_word(OP_LIT, 0, -7, 0, 0);
        send_word(OP_OPR, 0, OPR_MOD, 0, 0);
        send_word(OP_OPR, 0, OPR_NEG, 0, 0);
        send_word(OP_OPR, 0, OPR_ODD, 0, 0);
        send_word(OP_OPR, 0, 14, 0, 0);
        send_word(OP_CAL, 3, 32'sh7fffffff, 0, 0);
        send_word(OP_LOD, 3, -1, 0, 0);
        send_word(OP_STO, 2, 3, 0, 0);
        send_word(OP_OPR, 0, OPR_RET, 0, 0);
        send_word(OP_JPC, 0, 100, 0, 0);
        send_word(OP_JMP, 0, -1, 0, 0);
        send_word(OP_SIO, 0, SIO_IN, 32'sh80000000, 0);
        send_word(OP_SIO, 0, SIO_OUT, 0, 0);
        send_word(OP_SIO, 0, 3, 0, 0);
        send_word(4'd15, 3, 0, 0, 0);
        send_word(OP_INC, 0, -5, 0, 0);
        send_word(OP_INC, 0, 32'sh7fffffff, 0, 0);

        // pause until every result is in
        while (pending != 0) @(posedge clk);
        stall_on = 1'b0;
        send_word(OP_INC, 0, 32'sh80000001, 0, 0);
        send_word(OP_INC, 0, 4, 0, 0);

        k = 0;
        while (k < 1040)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 3)
            begin
                send_rand(ACTION_W'($urandom_range(10, 15)), rand_word());
            end
            else if (choice < 25)
            begin
                send_rand(OP_LIT, rand_word());
            end
            else if (choice < 55)
            begin
                send_rand(OP_OPR, $urandom_range(0, 100) < 95 ?
                          $urandom_range(1, 13) : rand_word());
            end
            else if (choice < 62)
            begin
                send_rand(OP_LOD, $urandom_range(0, 8) - 2);
            end
            else if (choice < 69)
            begin
                send_rand(OP_STO, $urandom_range(0, 8) - 2);
            end
            else if (choice < 74)
            begin
                send_rand(OP_CAL, rand_word());
                send_rand(OP_INC, $urandom_range(0, 6));
                send_rand(OP_LIT, rand_word());
                send_rand(OP_OPR, OPR_RET);
                k += 3;
            end
            else if (choice < 78)
            begin
                send_rand(OP_INC, $urandom_range(0, 10) == 0 ? rand_word()
                          : $urandom_range(0, 6) - 3);
            end
            else if (choice < 82)
            begin
                send_rand(OP_JMP, rand_word());
            end
            else if (choice < 87)
            begin
                send_rand(OP_JPC, rand_word());
            end
            else
            begin
                send_rand(OP_SIO, $urandom_range(0, 20) == 0 ? rand_word()
                          : $urandom_range(0, 1));
            end
            stall_on = ($urandom_range(0, 200) != 0) ? stall_on : !stall_on;
            k++;
        end
        stall_on = 1'b1;
        send_word(OP_SIO, 0, SIO_HALT, 0, 0);
        send_word(OP_LIT, 0, 5, 0, 3);
        send_word(OP_SIO, 0, SIO_OUT, 0, 0);

        k = 0;
        while (pending != 0 && k < 100000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[stack_machine_execute_unit_top.f]
src/smeu_pkg.sv
src/smeu_ram.sv
src/smeu_div.sv
src/smeu_dp.sv
src/smeu_ctrl.sv
src/stack_machine_execute_unit_top.sv
src/smeu_checker.sv
bench/stack_machine_execute_unit_checker.sv
bench/stack_machine_execute_unit_top_test.sv
